/* design/cle_pkg.sv */
// shared types, character codes and echo sequence functions for the console line editor
`timescale 1ns / 1ps
package cle_pkg;

   // character codes
   localparam logic [7:0] CH_ZERO  = 8'h00;
   localparam logic [7:0] CH_BS    = 8'h08;
   localparam logic [7:0] CH_LF    = 8'h0A;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_FS    = 8'h1C;
   localparam logic [7:0] CH_SP    = 8'h20;
   localparam logic [7:0] CH_DEL   = 8'h7F;
   localparam logic [7:0] CH_CARET = 8'h5E;
   localparam logic [7:0] CH_DIGIT0 = 8'h30;
   localparam logic [7:0] CH_BSLASH = 8'h5C;
   localparam logic [7:0] CARET_OFFSET = 8'h40;

   // job queue depth
   localparam int Q_DEPTH = 4;

   // result kinds
   typedef enum logic [1:0] {
      KIND_ECHO = 2'd0,
      KIND_DATA = 2'd1,
      KIND_WAIT = 2'd2
   } kind_type;

   // jobs handed from the front to the back
   typedef enum logic [2:0] {
      OP_PLAIN       = 3'd0,
      OP_CARET       = 3'd1,
      OP_NEWLINE     = 3'd2,
      OP_ERASE_CTRL  = 3'd3,
      OP_ERASE_PRINT = 3'd4,
      OP_DATA        = 3'd5,
      OP_WAIT        = 3'd6
   } op_type;

   typedef struct packed {
      op_type     op;
      logic [7:0] ch;
   } job_type;

   typedef struct packed {
      logic    valid;
      job_type job;
   } push_type;

   typedef struct packed {
      logic full;
      logic empty;
   } q_status_type;

   // second character of caret notation
   function automatic logic [7:0] caret_char(input logic [7:0] ch);
      logic [7:0] res;
      if (ch == CH_ZERO) begin
         res = CH_DIGIT0;
      end else if (ch == CH_FS) begin
         res = CH_BSLASH;
      end else begin
         res = ch + CARET_OFFSET;
      end
      return res;
   endfunction

   // number of result items a job produces
   function automatic logic [2:0] seq_len(input op_type op);
      logic [2:0] res;
      unique case (op)
         OP_CARET, OP_NEWLINE: res = 3'd2;
         OP_ERASE_CTRL:        res = 3'd6;
         OP_ERASE_PRINT:       res = 3'd3;
         default:              res = 3'd1;
      endcase
      return res;
   endfunction

   // result kind of a job
   function automatic kind_type seq_kind(input op_type op);
      kind_type res;
      unique case (op)
         OP_DATA: res = KIND_DATA;
         OP_WAIT: res = KIND_WAIT;
         default: res = KIND_ECHO;
      endcase
      return res;
   endfunction

   // data byte at a given step of a job
   function automatic logic [7:0] seq_char(input op_type op, input logic [7:0] ch,
                                           input logic [2:0] step);
      logic [7:0] res;
      unique case (op)
         OP_CARET: begin
            res = (step == 3'd0) ? CH_CARET : caret_char(ch);
         end
         OP_NEWLINE: begin
            res = (step == 3'd0) ? CH_CR : CH_LF;
         end
         OP_ERASE_CTRL: begin
            res = (step == 3'd2 || step == 3'd3) ? CH_SP : CH_BS;
         end
         OP_ERASE_PRINT: begin
            res = (step == 3'd1) ? CH_SP : CH_BS;
         end
         OP_WAIT: begin
            res = CH_ZERO;
         end
         default: begin
            res = ch;
         end
      endcase
      return res;
   endfunction

endpackage

/* design/cle_req_if.sv */
// request channel interface: received byte or read request
`timescale 1ns / 1ps
interface cle_req_if;
   logic       valid;
   logic       ready;
   logic       cmd;
   logic [7:0] rx_byte;

   modport source (output valid, output cmd, output rx_byte, input ready);
   modport sink (input valid, input cmd, input rx_byte, output ready);
endinterface

/* design/cle_rsp_if.sv */
// response channel interface: echo bytes, read data and not-ready reports
`timescale 1ns / 1ps
interface cle_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] kind;
   logic [7:0] data;
   logic       last;

   modport source (output valid, output kind, output data, output last, input ready);
   modport sink (input valid, input kind, input data, input last, output ready);
endinterface

/* design/cle_front.sv */
// front end: accepts items, keeps the line buffer and counters, issues echo, data and not-ready jobs
`timescale 1ns / 1ps
module cle_front #(
   parameter int DEPTH = 64
) (
   input  logic                  clock,
   input  logic                  reset,
   cle_req_if.sink               req,
   input  logic                  csr_we,
   input  logic                  csr_wdata,
   input  cle_pkg::q_status_type q_status,
   output cle_pkg::push_type     push
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);
   localparam logic [AW-1:0] PTR_LAST = AW'(DEPTH - 1);
   localparam logic [CW-1:0] FILL_FULL = CW'(DEPTH);

   typedef enum logic [2:0] {
      ST_RUN   = 3'b001,
      ST_READ  = 3'b010,
      ST_ERASE = 3'b100
   } front_state_type;

   front_state_type state_ff, state_in;
   logic [AW-1:0] rptr_ff, rptr_in;
   logic [AW-1:0] wptr_ff, wptr_in;
   logic [CW-1:0] fill_ff, fill_in;
   logic [CW-1:0] nl_ff, nl_in;
   logic          echo_ff;
   logic [7:0]    rdata_ff;
   logic [7:0]    mem [DEPTH];

   logic          accept;
   logic [7:0]    ch_map;
   logic          is_erase;
   logic          mem_we;
   logic [AW-1:0] rd_addr;
   logic [AW-1:0] wptr_prev;
   logic [AW-1:0] rptr_next;
   logic [AW-1:0] wptr_next;

   // handshake and character mapping
   assign req.ready = (state_ff == ST_RUN) && !q_status.full;
   assign accept    = req.valid && req.ready;
   assign ch_map    = (req.rx_byte == cle_pkg::CH_CR) ? cle_pkg::CH_LF : req.rx_byte;
   assign is_erase  = (ch_map == cle_pkg::CH_BS) || (ch_map == cle_pkg::CH_DEL);

   // ring pointer steps
   assign rptr_next = (rptr_ff == PTR_LAST) ? '0 : rptr_ff + 1'b1;
   assign wptr_next = (wptr_ff == PTR_LAST) ? '0 : wptr_ff + 1'b1;
   assign wptr_prev = (wptr_ff == '0) ? PTR_LAST : wptr_ff - 1'b1;

   // item decode and buffer bookkeeping
   always_comb begin
      state_in = state_ff;
      rptr_in  = rptr_ff;
      wptr_in  = wptr_ff;
      fill_in  = fill_ff;
      nl_in    = nl_ff;
      mem_we   = 1'b0;
      rd_addr  = rptr_ff;
      push     = '0;
      unique case (state_ff)
         ST_RUN: begin
            if (accept) begin
               if (req.cmd) begin
                  if (nl_ff == '0 || fill_ff == '0) begin
                     push.valid  = 1'b1;
                     push.job.op = cle_pkg::OP_WAIT;
                  end else begin
                     rd_addr  = rptr_ff;
                     state_in = ST_READ;
                  end
               end else if (is_erase && echo_ff) begin
                  if (fill_ff != '0) begin
                     rd_addr  = wptr_prev;
                     state_in = ST_ERASE;
                  end
               end else if (fill_ff != FILL_FULL) begin
                  mem_we  = 1'b1;
                  wptr_in = wptr_next;
                  fill_in = fill_ff + 1'b1;
                  if (ch_map == cle_pkg::CH_LF) begin
                     nl_in = nl_ff + 1'b1;
                  end
                  if (echo_ff) begin
                     push.valid  = 1'b1;
                     push.job.ch = ch_map;
                     if (ch_map == cle_pkg::CH_LF) begin
                        push.job.op = cle_pkg::OP_NEWLINE;
                     end else if (ch_map < cle_pkg::CH_SP) begin
                        push.job.op = cle_pkg::OP_CARET;
                     end else begin
                        push.job.op = cle_pkg::OP_PLAIN;
                     end
                  end
               end
            end
         end
         ST_READ: begin
            rptr_in     = rptr_next;
            fill_in     = fill_ff - 1'b1;
            if (rdata_ff == cle_pkg::CH_LF) begin
               nl_in = nl_ff - 1'b1;
            end
            push.valid  = 1'b1;
            push.job.op = cle_pkg::OP_DATA;
            push.job.ch = rdata_ff;
            state_in    = ST_RUN;
         end
         ST_ERASE: begin
            if (rdata_ff != cle_pkg::CH_LF) begin
               wptr_in     = wptr_prev;
               fill_in     = fill_ff - 1'b1;
               push.valid  = 1'b1;
               push.job.ch = rdata_ff;
               push.job.op = (rdata_ff < cle_pkg::CH_SP) ? cle_pkg::OP_ERASE_CTRL
                                                          : cle_pkg::OP_ERASE_PRINT;
            end
            state_in = ST_RUN;
         end
         default: begin
            state_in = ST_RUN;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_RUN;
         rptr_ff  <= '0;
         wptr_ff  <= '0;
         fill_ff  <= '0;
         nl_ff    <= '0;
         echo_ff  <= 1'b1;
      end else begin
         state_ff <= state_in;
         rptr_ff  <= rptr_in;
         wptr_ff  <= wptr_in;
         fill_ff  <= fill_in;
         nl_ff    <= nl_in;
         if (csr_we) begin
            echo_ff <= csr_wdata;
         end
      end
   end

   // line buffer write port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[wptr_ff] <= ch_map;
      end
   end

   // line buffer read port
   always_ff @(posedge clock) begin
      rdata_ff <= mem[rd_addr];
   end

endmodule

/* design/cle_queue.sv */
// short job queue between the front end and the result sequencer
`timescale 1ns / 1ps
module cle_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  cle_pkg::push_type     push,
   input  logic                  pop,
   output cle_pkg::job_type      head,
   output cle_pkg::q_status_type status
);

   localparam int QAW = $clog2(cle_pkg::Q_DEPTH);
   localparam int QCW = $clog2(cle_pkg::Q_DEPTH + 1);
   localparam logic [QCW-1:0] Q_FULL = QCW'(cle_pkg::Q_DEPTH);

   cle_pkg::job_type entry_ff [cle_pkg::Q_DEPTH];
   logic [QAW-1:0]   wr_ff, wr_in;
   logic [QAW-1:0]   rd_ff, rd_in;
   logic [QCW-1:0]   cnt_ff, cnt_in;
   logic             do_push;
   logic             do_pop;

   assign status.full  = (cnt_ff == Q_FULL);
   assign status.empty = (cnt_ff == '0);
   assign head         = entry_ff[rd_ff];
   assign do_push      = push.valid && !status.full;
   assign do_pop       = pop && !status.empty;

   // pointer and count update
   always_comb begin
      wr_in  = do_push ? wr_ff + 1'b1 : wr_ff;
      rd_in  = do_pop ? rd_ff + 1'b1 : rd_ff;
      cnt_in = cnt_ff;
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   // job storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ff] <= push.job;
      end
   end

endmodule

/* design/cle_back.sv */
// back end: expands each job into its result items through an output register
`timescale 1ns / 1ps
module cle_back (
   input  logic                  clock,
   input  logic                  reset,
   input  cle_pkg::job_type      head,
   input  cle_pkg::q_status_type q_status,
   output logic                  pop,
   cle_rsp_if.source             rsp
);

   cle_pkg::job_type cur_ff, cur_in;
   logic             cur_valid_ff, cur_valid_in;
   logic [2:0]       step_ff, step_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [1:0]       kind_ff;
   logic [7:0]       data_ff;
   logic             last_ff;

   logic             out_free;
   logic             emit;
   logic             is_last;
   logic             load;

   assign rsp.valid = rsp_valid_ff;
   assign rsp.kind  = kind_ff;
   assign rsp.data  = data_ff;
   assign rsp.last  = last_ff;

   // step sequencing
   assign out_free = !rsp_valid_ff || rsp.ready;
   assign emit     = out_free && cur_valid_ff;
   assign is_last  = (step_ff == cle_pkg::seq_len(cur_ff.op) - 3'd1);
   assign load     = !cur_valid_ff || (emit && is_last);
   assign pop      = load && !q_status.empty;

   always_comb begin
      cur_in       = pop ? head : cur_ff;
      cur_valid_in = load ? !q_status.empty : cur_valid_ff;
      step_in      = load ? 3'd0 : (emit ? step_ff + 3'd1 : step_ff);
      rsp_valid_in = emit ? 1'b1 : (rsp.ready ? 1'b0 : rsp_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_valid_ff <= 1'b0;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cur_valid_ff <= cur_valid_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // job and result payload
   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
      if (emit) begin
         kind_ff <= cle_pkg::seq_kind(cur_ff.op);
         data_ff <= cle_pkg::seq_char(cur_ff.op, cur_ff.ch, step_ff);
         last_ff <= is_last;
      end
   end

endmodule

/* design/console_line_editor_echo.sv */
// top level of the console line editor with echo
//
//   channel   direction  contents
//   req_if    in         cmd (byte or read), rx_byte
//   rsp_if    out        kind (echo, data, not ready), data, last
//   csr_      in         csr_we, csr_wdata = echo enable
//
// A read of line data or an erase of a buffered byte passes through a
// second state (ST_READ or ST_ERASE), since the line buffer read port is
// registered; a stored or dropped byte, a read with no complete line and an
// erase of an empty buffer do not. Results leave at one per cycle while the
// result side is not stalled; an erase of a control byte gives six results.
// Reset is synchronous and needs no clearing pass; echo comes up enabled.
// A stalled result side fills the four-entry job queue, then holds off req.
`timescale 1ns / 1ps
module console_line_editor_echo #(
   parameter int DEPTH = 64
) (
   input  logic       clock,
   input  logic       reset,
   cle_req_if.sink    req_if,
   cle_rsp_if.source  rsp_if,
   input  logic       csr_we,
   input  logic       csr_wdata
);

   cle_pkg::push_type     push;
   cle_pkg::job_type      head;
   cle_pkg::q_status_type q_status;
   logic                  pop;

   // accept and classify
   cle_front #(
      .DEPTH (DEPTH)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req       (req_if),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .q_status  (q_status),
      .push      (push)
   );

   // job queue
   cle_queue u_queue (
      .clock  (clock),
      .reset  (reset),
      .push   (push),
      .pop    (pop),
      .head   (head),
      .status (q_status)
   );

   // result sequencing
   cle_back u_back (
      .clock    (clock),
      .reset    (reset),
      .head     (head),
      .q_status (q_status),
      .pop      (pop),
      .rsp      (rsp_if)
   );

endmodule
